// ----- rtl/rcf_pkg.sv -----
// Shared types, constants and lookup functions for the rotor cipher core.
// Used by the controller, datapath and top level; depends on nothing else.
`default_nettype none
package rcf_pkg;

    localparam int SYMBOLS     = 94;
    localparam int ROTORS      = 5;
    localparam int TABLE_CHARS = 93;
    localparam int SYM_W       = 7;
    localparam int ROT_W       = 3;
    localparam int WADDR_W     = 9;
    localparam int WIRE_DEPTH  = ROTORS * SYMBOLS;
    localparam int CNT_W       = 8;
    localparam int STAGE_W     = 4;
    localparam int LAST_STAGE  = 2 * ROTORS;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 1;

    // Character set, first character in the highest byte.
    localparam logic [8*TABLE_CHARS-1:0] CHAR_STR =
        " abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!@#$%^&*()-_=+[{]};:'\",<.>/?\\|";

    typedef enum logic [1:0] {
        KIND_WIRING = 2'd0,
        KIND_REFL   = 2'd1,
        KIND_POS    = 2'd2,
        KIND_ENC    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ROT_W-1:0]   which_rotor;
        logic [SYM_W-1:0]   entry_index;
        logic [SYM_W-1:0]   entry_value;
        logic               notch_flag;
        logic [7:0]         char_in;
        logic [SYM_W-1:0]   timing_steps;
    } item_t;

    typedef struct packed {
        logic clear_wr;
        logic item_load;
        logic wiring_wr;
        logic refl_wr_a;
        logic refl_wr_b;
        logic pos_wr;
        logic enc_init;
        logic step_up;
        logic pass_up;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  clear_done;
        logic  item_ok;
        logic  mapped;
        logic  steps_last;
        logic  pass_last;
        kind_t kind;
    } status_t;

    // Returns {found, index}.
    function automatic logic [SYM_W:0] sym_lookup(input logic [7:0] c);
        logic [SYM_W:0] res;
        res = '0;
        for (int i = 0; i < TABLE_CHARS; i++) begin
            if (CHAR_STR[8*(TABLE_CHARS-1-i) +: 8] == c) begin
                res = {1'b1, SYM_W'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] char_at(input logic [SYM_W-1:0] idx);
        logic [7:0] res;
        res = 8'd0;
        for (int i = 0; i < TABLE_CHARS; i++) begin
            if (idx == SYM_W'(i)) begin
                res = CHAR_STR[8*(TABLE_CHARS-1-i) +: 8];
            end
        end
        return res;
    endfunction

    // Valid for inputs below twice the symbol count.
    function automatic logic [SYM_W-1:0] mod_sym(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v >= CNT_W'(SYMBOLS)) ? v - CNT_W'(SYMBOLS) : v;
        return r[SYM_W-1:0];
    endfunction

    function automatic logic [WADDR_W-1:0] rotor_base(input logic [ROT_W-1:0] r);
        logic [WADDR_W-1:0] res;
        res = '0;
        for (int i = 0; i < ROTORS; i++) begin
            if (r == ROT_W'(i)) begin
                res = WADDR_W'(i * SYMBOLS);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rcf_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`default_nettype none
module rcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/rcf_ctrl.sv -----
// Controller state machine of the rotor cipher core.
// Depends on rcf_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none
module rcf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire rcf_pkg::status_t status,
    output rcf_pkg::cmd_t         cmd
);
    import rcf_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_REFL,
        ST_STEP_RD,
        ST_STEP_UP,
        ST_PASS_RD,
        ST_PASS_UP,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.kind)
                    KIND_WIRING: begin
                        cmd.wiring_wr = status.item_ok;
                        state_next    = ST_IDLE;
                    end
                    KIND_REFL: begin
                        cmd.refl_wr_a = status.item_ok;
                        state_next    = status.item_ok ? ST_REFL : ST_IDLE;
                    end
                    KIND_POS: begin
                        cmd.pos_wr = status.item_ok;
                        state_next = ST_IDLE;
                    end
                    KIND_ENC: begin
                        cmd.enc_init = 1'b1;
                        state_next   = ST_STEP_RD;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_REFL: begin
                // Second half of the pair: partner points back.
                cmd.refl_wr_b = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_STEP_RD: begin
                // Notch reads for the current positions land next cycle.
                state_next = status.mapped ? ST_STEP_UP : ST_OUT;
            end
            ST_STEP_UP: begin
                cmd.step_up = 1'b1;
                state_next  = status.steps_last ? ST_PASS_RD : ST_STEP_RD;
            end
            ST_PASS_RD: begin
                state_next = ST_PASS_UP;
            end
            ST_PASS_UP: begin
                cmd.pass_up = 1'b1;
                state_next  = status.pass_last ? ST_OUT : ST_PASS_RD;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rcf_datapath.sv -----
// Datapath of the rotor cipher core: wiring, notch and reflector RAMs,
// rotor positions, step counter and signal register. Depends on rcf_pkg, rcf_ram.
`default_nettype none
module rcf_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire rcf_pkg::cmd_t  cmd,
    input  wire rcf_pkg::item_t s_item,
    output rcf_pkg::status_t    status,
    output logic [7:0]          out_char,
    output logic                out_mapped
);
    import rcf_pkg::*;

    item_t              item_reg;
    logic [SYM_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SYM_W-1:0]   pos_reg [ROTORS];
    logic [SYM_W-1:0]   pos_next [ROTORS];
    logic [SYM_W-1:0]   salt_reg, salt_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [SYM_W-1:0]   sig_reg, sig_next;
    logic               mapped_reg, mapped_next;
    logic [7:0]         out_char_reg;
    logic               out_mapped_reg;

    logic [ROT_W-1:0]   stage_rot;
    logic [SYM_W-1:0]   pos_sel;
    logic [SYM_W-1:0]   contact;
    logic [WADDR_W-1:0] wire_raddr;
    logic [SYM_W-1:0]   fwd_rd, inv_rd, refl_rd, pass_rd;
    logic [SYM_W-1:0]   wired;
    logic [SYM_W:0]     lookup;
    logic [SYM_W-1:0]   timing_mod;
    logic [ROTORS-1:0]  notch_rd;
    logic               s1, s2, s3, s4;
    logic               item_in_range, rotor_ok;

    // Wiring RAMs: rotor r occupies entries r*SYMBOLS .. r*SYMBOLS+SYMBOLS-1.
    rcf_ram #(.WIDTH(SYM_W), .DEPTH(WIRE_DEPTH)) u_fwd (
        .aclk  (aclk),
        .we    (cmd.wiring_wr),
        .waddr (rotor_base(item_reg.which_rotor) + WADDR_W'(item_reg.entry_index)),
        .wdata (item_reg.entry_value),
        .raddr (wire_raddr),
        .rdata (fwd_rd)
    );

    rcf_ram #(.WIDTH(SYM_W), .DEPTH(WIRE_DEPTH)) u_inv (
        .aclk  (aclk),
        .we    (cmd.wiring_wr),
        .waddr (rotor_base(item_reg.which_rotor) + WADDR_W'(item_reg.entry_value)),
        .wdata (item_reg.entry_index),
        .raddr (wire_raddr),
        .rdata (inv_rd)
    );

    rcf_ram #(.WIDTH(SYM_W), .DEPTH(SYMBOLS)) u_refl (
        .aclk  (aclk),
        .we    (cmd.refl_wr_a || cmd.refl_wr_b),
        .waddr (cmd.refl_wr_a ? item_reg.entry_index : item_reg.entry_value),
        .wdata (cmd.refl_wr_a ? item_reg.entry_value : item_reg.entry_index),
        .raddr (sig_reg),
        .rdata (refl_rd)
    );

    // Rotor 1's notch is never consulted by the stepping rule, so it has no store.
    for (genvar r = 0; r < ROTORS; r++) begin : g_notch
        if (r != 1) begin : g_ram
            rcf_ram #(.WIDTH(1), .DEPTH(SYMBOLS)) u_notch (
                .aclk  (aclk),
                .we    (cmd.clear_wr ||
                        (cmd.wiring_wr && item_reg.which_rotor == ROT_W'(r))),
                .waddr (cmd.clear_wr ? clr_cnt_reg : item_reg.entry_index),
                .wdata (cmd.clear_wr ? 1'b0 : item_reg.notch_flag),
                .raddr (pos_reg[r]),
                .rdata (notch_rd[r])
            );
        end else begin : g_none
            assign notch_rd[r] = 1'b0;
        end
    end

    always_comb begin
        if (stage_reg < STAGE_W'(ROTORS)) begin
            stage_rot = stage_reg[ROT_W-1:0];
        end else if (stage_reg > STAGE_W'(ROTORS)) begin
            stage_rot = ROT_W'(STAGE_W'(LAST_STAGE) - stage_reg);
        end else begin
            stage_rot = '0;
        end
    end

    assign pos_sel    = pos_reg[stage_rot];
    assign contact    = mod_sym(CNT_W'(sig_reg) + CNT_W'(pos_sel));
    assign wire_raddr = rotor_base(stage_rot) + WADDR_W'(contact);

    always_comb begin
        if (stage_reg < STAGE_W'(ROTORS)) begin
            pass_rd = fwd_rd;
        end else if (stage_reg == STAGE_W'(ROTORS)) begin
            pass_rd = refl_rd;
        end else begin
            pass_rd = inv_rd;
        end
    end

    assign wired      = mod_sym(CNT_W'(pass_rd));
    assign lookup     = sym_lookup(item_reg.char_in);
    assign timing_mod = mod_sym(CNT_W'(item_reg.timing_steps));

    assign s1 = notch_rd[0];
    assign s2 = s1 && notch_rd[2];
    assign s3 = s2 && notch_rd[3];
    assign s4 = s3 && notch_rd[4];

    assign rotor_ok      = item_reg.which_rotor < ROT_W'(ROTORS);
    assign item_in_range = (item_reg.entry_index < SYM_W'(SYMBOLS)) &&
                           (item_reg.entry_value < SYM_W'(SYMBOLS));

    always_comb begin
        case (item_reg.kind)
            KIND_WIRING: status.item_ok = rotor_ok && item_in_range;
            KIND_REFL:   status.item_ok = item_in_range;
            KIND_POS:    status.item_ok = rotor_ok &&
                                          (item_reg.entry_value < SYM_W'(SYMBOLS));
            default:     status.item_ok = 1'b1;
        endcase
    end

    assign status.clear_done = (clr_cnt_reg == SYM_W'(SYMBOLS - 1));
    assign status.mapped     = mapped_reg;
    assign status.steps_last = (cnt_reg == CNT_W'(1));
    assign status.pass_last  = (stage_reg == STAGE_W'(LAST_STAGE));
    assign status.kind       = item_reg.kind;

    always_comb begin
        clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + SYM_W'(1) : clr_cnt_reg;
        pos_next     = pos_reg;
        salt_next    = salt_reg;
        cnt_next     = cnt_reg;
        stage_next   = stage_reg;
        sig_next     = sig_reg;
        mapped_next  = mapped_reg;
        if (cmd.pos_wr) begin
            for (int r = 0; r < ROTORS; r++) begin
                if (item_reg.which_rotor == ROT_W'(r)) begin
                    pos_next[r] = item_reg.entry_value;
                end
            end
        end
        if (cmd.enc_init) begin
            mapped_next = lookup[SYM_W];
            sig_next    = lookup[SYM_W-1:0];
            cnt_next    = CNT_W'(1) + CNT_W'(timing_mod) + CNT_W'(salt_reg);
            stage_next  = '0;
        end
        if (cmd.step_up) begin
            // All notch tests use the positions from before this step.
            pos_next[0] = mod_sym(CNT_W'(pos_reg[0]) + CNT_W'(1));
            if (s1) pos_next[1] = mod_sym(CNT_W'(pos_reg[1]) + CNT_W'(1));
            if (s2) pos_next[2] = mod_sym(CNT_W'(pos_reg[2]) + CNT_W'(1));
            if (s3) pos_next[3] = mod_sym(CNT_W'(pos_reg[3]) + CNT_W'(1));
            if (s4) pos_next[4] = mod_sym(CNT_W'(pos_reg[4]) + CNT_W'(1));
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.pass_up) begin
            if (stage_reg == STAGE_W'(ROTORS)) begin
                sig_next = wired;
            end else begin
                sig_next = mod_sym(CNT_W'(wired) + CNT_W'(SYMBOLS) - CNT_W'(pos_sel));
            end
            stage_next = stage_reg + STAGE_W'(1);
            if (stage_reg == STAGE_W'(LAST_STAGE)) begin
                salt_next = sig_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            salt_reg    <= '0;
            for (int r = 0; r < ROTORS; r++) begin
                pos_reg[r] <= '0;
            end
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            salt_reg    <= salt_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_item;
        end
        cnt_reg    <= cnt_next;
        stage_reg  <= stage_next;
        sig_reg    <= sig_next;
        mapped_reg <= mapped_next;
        if (cmd.out_load) begin
            out_char_reg   <= mapped_reg ? char_at(sig_reg) : item_reg.char_in;
            out_mapped_reg <= mapped_reg;
        end
    end

    assign out_char   = out_char_reg;
    assign out_mapped = out_mapped_reg;

endmodule
`default_nettype wire

// ----- rtl/rotor_cipher_with_feedback_core.sv -----
// Top level of the five-rotor cipher core with ciphertext feedback.
// Depends on rcf_pkg, rcf_ctrl and rcf_datapath.
//
// After reset the core clears the notch stores and holds s_tready low
// meanwhile. Each word carries a kind in s_tuser. An encrypt word runs N
// rotor steps with N = 1 + timing_steps mod 94 + the previous result index
// (up to 187); every rotor step is a notch RAM read followed by a position
// update, and the eleven wiring and reflector lookups each take a RAM read
// followed by an update. A byte outside the character set returns unchanged
// with was_mapped low. Loads return no word; a reflector load writes an
// entry and then its partner. A finished word waits in the output register
// while loads continue.
`default_nettype none
module rotor_cipher_with_feedback_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // From bit 0: which_rotor[2:0], entry_index[9:3], entry_value[16:10],
    // notch_flag[17], char_in[25:18], timing_steps[32:26], zeros above.
    input  wire logic [rcf_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  wire logic [rcf_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // char_out[7:0]
    output logic      [rcf_pkg::M_TDATA_W-1:0]   m_tdata,
    // was_mapped[0]
    output logic      [rcf_pkg::M_TUSER_W-1:0]   m_tuser
);
    import rcf_pkg::*;

    cmd_t    cmd;
    status_t status;
    item_t   s_item;

    assign s_item.kind         = kind_t'(s_tuser);
    assign s_item.which_rotor  = s_tdata[2:0];
    assign s_item.entry_index  = s_tdata[9:3];
    assign s_item.entry_value  = s_tdata[16:10];
    assign s_item.notch_flag   = s_tdata[17];
    assign s_item.char_in      = s_tdata[25:18];
    assign s_item.timing_steps = s_tdata[32:26];

    rcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcf_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_item     (s_item),
        .status     (status),
        .out_char   (m_tdata),
        .out_mapped (m_tuser[0])
    );

endmodule
`default_nettype wire

// ----- rtl/rcf_checker.sv -----
// Port-level assertions for the rotor cipher core and the bind that attaches them.
// Depends on rotor_cipher_with_feedback_core's port list.
`default_nettype none
module rcf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [0:0]  m_tuser
);

    // Reset empties the output and starts the notch clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output valid or input ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    // An accepted word leaves the core busy in the very next cycle, and no
    // result can appear in it.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("core ready or result raised right after an accepted word");

endmodule

bind rotor_cipher_with_feedback_core rcf_checker u_rcf_checker (.*);
`default_nettype wire
